@@ rtl/cmc_pkg.sv @@
`default_nettype none
package cmc_pkg;
   localparam int COST_BITS = 26;
   localparam int START_BITS = 5;
   localparam int IN_WEIGHT_BITS = 16;

   typedef struct packed {
      logic [IN_WEIGHT_BITS-1:0] pile_weight;
      logic                      is_last;
   } req_payload_type;

   typedef struct packed {
      logic [COST_BITS-1:0]  best_cost;
      logic [START_BITS-1:0] best_start;
      logic                  overflow_count;
   } rsp_payload_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;        // Store one pile.
      logic clear;       // Restart the ring.
      logic sum_step;    // One range-sum entry.
      logic base_step;   // One zero-length cost entry.
      logic dp_step;     // One phase of a split candidate.
      logic pick_step;   // One phase of a start candidate.
      logic take_result; // Latch the result.
   } cmc_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic sum_done;
      logic base_done;
      logic dp_done;
      logic pick_done;
      logic single;
   } cmc_status_type;
endpackage
`default_nettype wire

@@ rtl/cmc_req_if.sv @@
`default_nettype none
interface cmc_req_if;
   import cmc_pkg::*;
   logic            valid;
   logic            ready;
   req_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

@@ rtl/cmc_rsp_if.sv @@
`default_nettype none
interface cmc_rsp_if;
   import cmc_pkg::*;
   logic            valid;
   logic            ready;
   rsp_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

@@ rtl/cmc_datapath.sv @@
`default_nettype none
module cmc_datapath #(
   parameter int MAX_PILES   = 32,
   parameter int WEIGHT_BITS = 16
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire cmc_pkg::cmc_cmd_type    cmd,
   input  wire logic [WEIGHT_BITS-1:0]  in_weight,
   input  wire logic                    maxm,
   output cmc_pkg::cmc_status_type      status,
   output logic [cmc_pkg::COST_BITS-1:0]  res_cost,
   output logic [cmc_pkg::START_BITS-1:0] res_start,
   output logic                         res_over
);
   import cmc_pkg::*;

   localparam int IDX_BITS = $clog2(MAX_PILES);
   localparam int CNT_BITS = $clog2(MAX_PILES + 1);
   localparam int DEPTH    = MAX_PILES * MAX_PILES;
   localparam int ADR_BITS = 2 * IDX_BITS;
   localparam int SUM_BITS = WEIGHT_BITS + IDX_BITS;
   // A ring cost never exceeds the total weight times n-1, so it fits without clipping.
   localparam int C_BITS   = SUM_BITS + IDX_BITS;
   localparam int W_BITS   = (C_BITS > COST_BITS) ? C_BITS : COST_BITS;
   localparam logic [W_BITS-1:0] C_SAT = W_BITS'({COST_BITS{1'b1}});

   logic [WEIGHT_BITS-1:0] wstore [MAX_PILES];
   logic [SUM_BITS-1:0]    smem [DEPTH];
   logic [C_BITS-1:0]      cmem [DEPTH];

   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                over_ff, over_in;
   logic [IDX_BITS-1:0] i_ff, i_in, l_ff, l_in, k_ff, k_in;
   logic [SUM_BITS-1:0] acc_ff, acc_in;
   logic [C_BITS-1:0]   best_ff, best_in;
   logic [IDX_BITS-1:0] bidx_ff, bidx_in;
   logic                first_ff, first_in;
   logic [1:0]          ph_ff, ph_in;

   logic [IDX_BITS-1:0] nm1, right, ln;
   logic [IDX_BITS:0]   wrap;
   logic [SUM_BITS-1:0] srd_ff;
   logic [C_BITS-1:0]   crd_a_ff, crd_b_ff;
   logic [ADR_BITS-1:0] a_addr, b_addr, s_addr;
   logic [C_BITS-1:0]   cand;
   logic [W_BITS-1:0]   best_w;
   logic                better_c;

   assign nm1  = IDX_BITS'(cnt_ff - 1'b1);
   // Ring index i+k+1 reduced modulo count.
   assign wrap = {1'b0, i_ff} + {1'b0, k_ff} + 1'b1;
   assign right = (wrap >= (IDX_BITS+1)'(cnt_ff)) ?
                  IDX_BITS'(wrap - (IDX_BITS+1)'(cnt_ff)) : IDX_BITS'(wrap);
   assign ln   = IDX_BITS'(l_ff - k_ff - 1'b1);
   assign a_addr = {i_ff, k_ff};
   assign b_addr = {right, ln};
   assign s_addr = {i_ff, l_ff};

   assign cand = C_BITS'(srd_ff) + crd_a_ff + crd_b_ff;
   assign better_c = maxm ? (cand > best_ff) : (cand < best_ff);
   assign best_w = W_BITS'(best_ff);

   // Memory reads are registered; dp steps run a two-phase read/compare cycle.
   always_ff @(posedge clock) begin
      srd_ff   <= smem[s_addr];
      crd_a_ff <= cmem[a_addr];
      crd_b_ff <= cmem[b_addr];
      if (cmd.load && cnt_ff < CNT_BITS'(MAX_PILES))
         wstore[IDX_BITS'(cnt_ff)] <= in_weight;
      if (cmd.sum_step)
         smem[{i_ff, l_ff}] <= acc_in;
      if (cmd.base_step)
         cmem[{i_ff, {IDX_BITS{1'b0}}}] <= '0;
      if (cmd.dp_step && ph_ff == 2'd1 && k_ff == IDX_BITS'(l_ff - 1'b1))
         cmem[{i_ff, l_ff}] <= (first_ff || better_c) ? cand : best_ff;
   end

   always_comb begin
      cnt_in = cnt_ff; over_in = over_ff;
      i_in = i_ff; l_in = l_ff; k_in = k_ff; acc_in = acc_ff;
      best_in = best_ff; bidx_in = bidx_ff; first_in = first_ff; ph_in = ph_ff;
      if (cmd.clear) begin
         cnt_in = '0; over_in = 1'b0;
      end
      if (cmd.load) begin
         if (cnt_ff < CNT_BITS'(MAX_PILES)) cnt_in = cnt_ff + 1'b1;
         else over_in = 1'b1;
         i_in = '0; l_in = '0; k_in = '0; acc_in = '0; ph_in = '0; first_in = 1'b1;
      end
      if (cmd.sum_step) begin
         acc_in = ((l_ff == '0) ? '0 : acc_ff) +
                  SUM_BITS'(wstore[IDX_BITS'(((IDX_BITS+1)'(i_ff) + (IDX_BITS+1)'(l_ff))
                   >= (IDX_BITS+1)'(cnt_ff) ? ((IDX_BITS+1)'(i_ff) + (IDX_BITS+1)'(l_ff)
                   - (IDX_BITS+1)'(cnt_ff)) : ((IDX_BITS+1)'(i_ff) + (IDX_BITS+1)'(l_ff)))]);
         if (l_ff == nm1) begin
            l_in = '0; i_in = i_ff + 1'b1;
            if (i_ff == nm1) i_in = '0;
         end else l_in = l_ff + 1'b1;
      end
      if (cmd.base_step) begin
         if (i_ff == nm1) begin
            i_in = '0; l_in = IDX_BITS'(1); k_in = '0; ph_in = '0; first_in = 1'b1;
         end else i_in = i_ff + 1'b1;
      end
      if (cmd.dp_step) begin
         if (ph_ff == 2'd0) ph_in = 2'd1;
         else begin
            ph_in = 2'd0;
            if (first_ff || better_c) best_in = cand;
            first_in = 1'b0;
            if (k_ff == IDX_BITS'(l_ff - 1'b1)) begin
               k_in = '0; first_in = 1'b1;
               if (i_ff == nm1) begin
                  i_in = '0; l_in = l_ff + 1'b1;
               end else i_in = i_ff + 1'b1;
            end else k_in = k_ff + 1'b1;
         end
      end
      if (cmd.pick_step) begin
         // Phase 0 addresses entry (i, n-1); phase 1 compares it.
         if (ph_ff == 2'd0) ph_in = 2'd1;
         else begin
            ph_in = 2'd0;
            if (i_ff == '0 || (maxm ? (crd_a_ff > best_ff) : (crd_a_ff < best_ff))) begin
               best_in = crd_a_ff; bidx_in = i_ff;
            end
            i_in = i_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0; over_ff <= 1'b0; ph_ff <= '0; first_ff <= 1'b1;
      end else begin
         cnt_ff <= cnt_in; over_ff <= over_in; ph_ff <= ph_in; first_ff <= first_in;
      end
      i_ff <= i_in; acc_ff <= acc_in; best_ff <= best_in; bidx_ff <= bidx_in;
      // During the pick sweep k holds n-1 so the shared read port sees (i, n-1).
      l_ff <= l_in;
      k_ff <= (cmd.pick_step || status.dp_done) ? nm1 : k_in;
      if (cmd.take_result) begin
         res_cost  <= (cnt_ff > CNT_BITS'(1)) ?
                      ((best_w > C_SAT) ? COST_BITS'(C_SAT) : COST_BITS'(best_w)) : '0;
         res_start <= (cnt_ff > CNT_BITS'(1)) ? START_BITS'(bidx_ff) : '0;
         res_over  <= over_ff;
      end
   end

   assign status.single    = cnt_ff <= CNT_BITS'(1);
   assign status.sum_done  = cmd.sum_step && i_ff == nm1 && l_ff == nm1;
   assign status.base_done = cmd.base_step && i_ff == nm1;
   assign status.dp_done   = cmd.dp_step && ph_ff == 2'd1 && k_ff == IDX_BITS'(l_ff - 1'b1)
                             && i_ff == nm1 && l_ff == nm1;
   assign status.pick_done = cmd.pick_step && ph_ff == 2'd1 && i_ff == nm1;
endmodule
`default_nettype wire

@@ rtl/cmc_ctrl.sv @@
`default_nettype none
module cmc_ctrl (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_fire,
   input  wire logic                     req_last,
   input  wire logic                     rsp_fire,
   input  wire cmc_pkg::cmc_status_type  status,
   output cmc_pkg::cmc_cmd_type          cmd,
   output logic                          req_ready,
   output logic                          rsp_valid
);
   import cmc_pkg::*;

   typedef enum logic [6:0] {
      S_LOAD = 7'b0000001, S_SUM = 7'b0000010, S_BASE = 7'b0000100,
      S_DP = 7'b0001000, S_PICK = 7'b0010000, S_TAKE = 7'b0100000,
      S_OUT = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      cmd.load = (state_ff == S_LOAD) && req_fire;
      unique case (state_ff)
         S_LOAD: if (req_fire && req_last) state_in = S_SUM;
         S_SUM: begin
            if (status.single) state_in = S_TAKE;
            else begin
               cmd.sum_step = 1'b1;
               if (status.sum_done) state_in = S_BASE;
            end
         end
         S_BASE: begin
            cmd.base_step = 1'b1;
            if (status.base_done) state_in = S_DP;
         end
         S_DP: begin
            cmd.dp_step = 1'b1;
            if (status.dp_done) state_in = S_PICK;
         end
         S_PICK: begin
            cmd.pick_step = 1'b1;
            if (status.pick_done) state_in = S_TAKE;
         end
         S_TAKE: begin
            cmd.take_result = 1'b1;
            state_in = S_OUT;
         end
         S_OUT: if (rsp_fire) begin
            cmd.clear = 1'b1;
            state_in = S_LOAD;
         end
         default: state_in = S_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_LOAD;
      else state_ff <= state_in;
   end

   assign req_ready = (state_ff == S_LOAD);
   assign rsp_valid = (state_ff == S_OUT);

`ifndef ASSERT_OFF
   a_no_dual: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid)) else $error("ready and valid together");
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_fire |=> rsp_valid) else $error("result dropped");
   a_take: assert property (@(posedge clock) disable iff (reset)
      cmd.take_result |=> rsp_valid) else $error("result not shown");
   a_dp_done: assert property (@(posedge clock) disable iff (reset)
      status.dp_done |-> cmd.dp_step) else $error("stray step");
`endif
endmodule
`default_nettype wire

@@ rtl/circular_merge_cost_dp.sv @@
`default_nettype none
// Piles are accepted one per cycle while the block is loading.
// After the last of n piles (n > 1) the controller runs these steps in order before the result is valid:
// n*n range sums, n base entries, two phases per split candidate, two per start, one latch.
// A single pile skips the sums and dp steps and goes straight to the result latch.
// Reset is synchronous and active high; it clears the pile count and the controller.
module circular_merge_cost_dp #(
   parameter int MAX_PILES   = 32,
   parameter int WEIGHT_BITS = 16
) (
   input wire logic  clock,
   input wire logic  reset,
   cmc_req_if.sink   req,
   cmc_rsp_if.source rsp,
   input wire logic  csr_write,
   input wire logic  csr_wdata
);
   import cmc_pkg::*;

   cmc_cmd_type    cmd;
   cmc_status_type status;
   logic           maxm_ff;
   logic [COST_BITS-1:0]  res_cost;
   logic [START_BITS-1:0] res_start;
   logic                  res_over;

   always_ff @(posedge clock) begin
      if (reset) maxm_ff <= 1'b0;
      else if (csr_write) maxm_ff <= csr_wdata;
   end

   cmc_ctrl u_ctrl (
      .clock, .reset,
      .req_fire(req.valid && req.ready),
      .req_last(req.payload.is_last),
      .rsp_fire(rsp.valid && rsp.ready),
      .status, .cmd,
      .req_ready(req.ready), .rsp_valid(rsp.valid)
   );

   cmc_datapath #(.MAX_PILES(MAX_PILES), .WEIGHT_BITS(WEIGHT_BITS)) u_dp (
      .clock, .reset, .cmd,
      .in_weight(WEIGHT_BITS'(req.payload.pile_weight)),
      .maxm(maxm_ff), .status, .res_cost, .res_start, .res_over
   );

   assign rsp.payload.best_cost      = res_cost;
   assign rsp.payload.best_start     = res_start;
   assign rsp.payload.overflow_count = res_over;
endmodule
`default_nettype wire

@@ tb/circular_merge_cost_dp_tb.sv @@
`default_nettype none
module circular_merge_cost_dp_tb;
   import cmc_pkg::*;

   localparam int MAX_PILES    = 32;
   localparam int WATCHDOG_MAX = 400000;
   localparam longint unsigned COST_SAT = 64'h3FFFFFF;

   logic clock;
   logic reset;
   logic csr_write;
   logic csr_wdata;

   cmc_req_if req_ch();
   cmc_rsp_if rsp_ch();

   circular_merge_cost_dp DUT (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch.sink),
      .rsp       (rsp_ch.source),
      .csr_write (csr_write),
      .csr_wdata (csr_wdata)
   );

   req_payload_type pending_piles[$];
   rsp_payload_type expected_rings[$];

   longint unsigned ring_weights[MAX_PILES];
   int unsigned     ring_len;
   bit              ring_dropped;
   bit              mode_max;

   int unsigned mismatches;
   int unsigned rings_checked;
   int unsigned piles_sent;
   int unsigned idle_cycles;
   int unsigned burst_left;
   int unsigned gap_left;
   int unsigned stall_phase;

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   function automatic bit is_better(longint unsigned cand, longint unsigned cur,
                                    bit maxm);
      return maxm ? (cand > cur) : (cand < cur);
   endfunction

   function automatic rsp_payload_type solve_merge_ring(int unsigned n, bit maxm, bit dropped);
      longint unsigned sums[MAX_PILES][MAX_PILES];
      longint unsigned cost[MAX_PILES][MAX_PILES];
      longint unsigned cur;
      longint unsigned cand;
      longint unsigned best;
      int unsigned     best_idx;
      bit              have;
      rsp_payload_type res;
      best = 0;
      best_idx = 0;
      if (n > 1) begin
         for (int i = 0; i < n; i++) begin
            sums[i][0] = ring_weights[i];
            for (int l = 1; l < n; l++) sums[i][l] = sums[i][l-1] + ring_weights[(i+l)%n];
            cost[i][0] = 0;
         end
         for (int l = 1; l < n; l++) begin
            for (int i = 0; i < n; i++) begin
               have = 0;
               cur = 0;
               for (int d = i; d < i + l; d++) begin
                  cand = sums[i][l] + cost[i][d-i] + cost[(d+1)%n][i+l-d-1];
                  if (!have || is_better(cand, cur, maxm)) begin
                     cur = cand;
                     have = 1;
                  end
               end
               cost[i][l] = cur;
            end
         end
         best = cost[0][n-1];
         for (int i = 1; i < n; i++) begin
            if (is_better(cost[i][n-1], best, maxm)) begin
               best = cost[i][n-1];
               best_idx = i;
            end
         end
      end
      res.best_cost = (best > COST_SAT) ? COST_SAT[COST_BITS-1:0] : best[COST_BITS-1:0];
      res.best_start = best_idx[START_BITS-1:0];
      res.overflow_count = dropped;
      return res;
   endfunction

   task automatic absorb_pile(req_payload_type p);
      if (ring_len < MAX_PILES) begin
         ring_weights[ring_len] = p.pile_weight;
         ring_len++;
      end else begin
         ring_dropped = 1;
      end
      if (p.is_last) begin
         expected_rings.push_back(solve_merge_ring(ring_len, mode_max, ring_dropped));
         ring_len = 0;
         ring_dropped = 0;
      end
   endtask

   // Sender: bursts of random length separated by random gaps.
   always @(posedge clock) begin
      req_payload_type nxt;
      bit              drive;
      if (reset) begin
         req_ch.valid <= 1'b0;
         burst_left <= 0;
         gap_left <= 0;
      end else begin
         drive = 0;
         nxt = req_ch.payload;
         if (req_ch.valid && req_ch.ready) begin
            absorb_pile(req_ch.payload);
            piles_sent++;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (gap_left > 0) begin
               gap_left <= gap_left - 1;
            end else if (pending_piles.size() > 0) begin
               nxt = pending_piles.pop_front();
               drive = 1;
               if (burst_left <= 1) begin
                  burst_left <= $urandom_range(1, 20);
                  gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end
            req_ch.valid <= drive;
            req_ch.payload <= nxt;
         end
      end
   end

   // Receiver: stall pattern changes between fully ready and random stalls.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         stall_phase <= 0;
      end else begin
         stall_phase <= stall_phase + 1;
         case ((stall_phase / 64) % 3)
            0: rsp_ch.ready <= 1'b1;
            1: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
            default: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   always @(posedge clock) begin
      rsp_payload_type exp_r;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         rings_checked++;
         if (expected_rings.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("Unexpected result transaction: %p", rsp_ch.payload);
         end else begin
            exp_r = expected_rings.pop_front();
            if (rsp_ch.payload.best_cost !== exp_r.best_cost
                || rsp_ch.payload.best_start !== exp_r.best_start
                || rsp_ch.payload.overflow_count !== exp_r.overflow_count) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"Mismatch: expected cost %0d start %0d ovf %0b,",
                            " got cost %0d start %0d ovf %0b"},
                           exp_r.best_cost, exp_r.best_start, exp_r.overflow_count,
                           rsp_ch.payload.best_cost, rsp_ch.payload.best_start,
                           rsp_ch.payload.overflow_count);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_MAX) begin
            $display("Watchdog expired with %0d results outstanding.", expected_rings.size());
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   task automatic queue_ring(int unsigned n, int unsigned style);
      req_payload_type p;
      for (int unsigned k = 0; k < n; k++) begin
         case (style)
            0: p.pile_weight = $urandom_range(0, 65535);
            1: p.pile_weight = 16'hFFFF;
            2: p.pile_weight = 16'h0000;
            3: p.pile_weight = $urandom_range(0, 3);
            default:
               p.pile_weight = ($urandom_range(0, 1) == 0) ? 16'hFFFF
                                                           : $urandom_range(0, 65535);
         endcase
         p.is_last = (k == n - 1);
         pending_piles.push_back(p);
      end
   endtask

   task automatic drain_and_set_mode(bit m);
      wait (pending_piles.size() == 0 && !req_ch.valid && expected_rings.size() == 0);
      repeat (20) @(posedge clock);
      csr_write <= 1'b1;
      csr_wdata <= m;
      @(posedge clock);
      csr_write <= 1'b0;
      mode_max = m;
   endtask

   function automatic int unsigned random_ring_len();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 80) return $urandom_range(1, 8);
      if (pick < 98) return $urandom_range(9, 16);
      return $urandom_range(30, 35);
   endfunction

   initial begin
      int unsigned budget;
      reset = 1'b1;
      csr_write = 1'b0;
      csr_wdata = 1'b0;
      req_ch.valid = 1'b0;
      req_ch.payload = '0;
      rsp_ch.ready = 1'b0;
      mode_max = 0;
      ring_len = 0;
      ring_dropped = 0;
      mismatches = 0;
      rings_checked = 0;
      piles_sent = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      for (int m = 0; m < 2; m++) begin
         drain_and_set_mode(m[0]);
         queue_ring(1, 2);
         queue_ring(1, 1);
         queue_ring(2, 0);
         queue_ring(3, 2);
         queue_ring(5, 1);
         queue_ring(32, 1);
         queue_ring(34, 4);
      end

      budget = 0;
      for (int phase = 0; phase < 6; phase++) begin
         drain_and_set_mode((phase % 2) == 0);
         while (budget < (phase + 1) * 250) begin
            int unsigned n;
            n = random_ring_len();
            queue_ring(n, $urandom_range(0, 4));
            budget += n;
         end
      end

      wait (pending_piles.size() == 0 && !req_ch.valid && expected_rings.size() == 0);
      repeat (50) @(posedge clock);
      $display("Sent %0d piles and checked %0d ring results in both cost modes,", piles_sent,
               rings_checked);
      $display("including single piles, full rings and rings with dropped piles.");
      if (mismatches == 0 && expected_rings.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Mismatches: %0d", mismatches);
         $display("Test completed with failures");
      end
      $finish;
   end
endmodule
`default_nettype wire
